// ----- design/afp_pkg.sv -----
// afp_pkg: constants, sequencer states and helpers of the additive feedback generator.
// Self-contained; imported by additive_feedback_prng.
`default_nettype none
package afp_pkg;

  localparam int unsigned Degree        = 31;
  localparam int unsigned Separation    = 3;
  localparam int unsigned DiscardFactor = 10;
  localparam int unsigned DiscardN      = Degree * DiscardFactor;

  localparam int unsigned IdxW  = $clog2(Degree);
  localparam int unsigned DiscW = $clog2(DiscardN);

  localparam int unsigned WordW  = 32;
  localparam int unsigned ValueW = 31;
  localparam int unsigned SeedW  = 32;

  // Schrage factorization of 16807 * x mod 2147483647
  localparam logic [31:0] SchQ = 32'd127773;
  localparam logic [14:0] SchA = 15'd16807;
  localparam logic [14:0] SchR = 15'd2836;
  localparam logic [32:0] SchM = 33'd2147483647;

  localparam int unsigned QuoW = 15;              // quotient of |x| / SchQ
  localparam int unsigned LoW  = 17;              // remainder below SchQ

  // floor(2^33 / SchQ); for |x| <= 2^31 the estimate is exact or one low
  localparam logic [16:0] SchC     = 17'd67228;
  localparam int unsigned SchShift = 33;
  localparam int unsigned ProdW    = WordW + LoW;

  localparam logic FuncDraw = 1'b0;
  localparam logic FuncSeed = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_ABS,
    ST_EST,
    ST_REM,
    ST_CORR,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUB,
    ST_FIX,
    ST_RD,
    ST_WB
  } state_e;

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] idx);
    next_idx = (idx == IdxW'(Degree - 1)) ? '0 : idx + IdxW'(1);
  endfunction

endpackage
`default_nettype wire

// ----- design/additive_feedback_prng.sv -----
// additive_feedback_prng: additive lagged-Fibonacci generator, 31-word lag table; uses afp_pkg.
// Draw: table read, then add and write-back, where the result is registered; a new request is
// taken only back in idle. Reseed: seed write, then 30 words of Schrage steps (reciprocal-multiply
//   divide, shared 17x32 multiplier), then 310 discard draws; a draw before any seed seeds first.
// A result held by the receiver stalls the sequencer in write-back until it is taken.
// Reset (async, active low) clears sequencer, indices and seeded flag; the table is not cleared.
`default_nettype none
module additive_feedback_prng import afp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] seed
  input  wire logic        s_axis_tuser_i,   // [0] func
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o    // [30:0] value, [31] zero
);

  state_e state_q, state_d;

  logic [IdxW-1:0]  front_q, rear_q, widx_q;
  logic             seeded_q, disc_q, pend_q;
  logic [DiscW-1:0] dcnt_q;
  logic             out_vld_q;
  logic [ValueW-1:0] out_val_q;

  logic [WordW-1:0] seed_q, prev_q, rem_q, p_lo_q, p_hi_q, rda_q, rdb_q;
  logic             neg_q;
  logic [QuoW-1:0]  quo_q;
  logic [32:0]      diff_q;

  logic [WordW-1:0] mem_q [Degree];

  logic             s_acc, out_free, last_word, last_disc;
  logic             mem_we, rd_en;
  logic [IdxW-1:0]  mem_waddr;
  logic [WordW-1:0] mem_wdata;
  logic [WordW-1:0] sum, mag;
  logic [LoW-1:0]   mul_a;
  logic [WordW-1:0] mul_b;
  logic [ProdW-1:0] prod;
  logic [32:0]      fixed;

  assign s_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_vld_q || m_axis_tready_i;
  assign last_word = (widx_q == IdxW'(Degree - 1));
  assign last_disc = (dcnt_q == DiscW'(DiscardN - 1));
  assign sum       = rda_q + rdb_q;
  assign mag       = prev_q[31] ? (~prev_q + 32'd1) : prev_q;
  assign prod      = ProdW'(mul_a) * ProdW'(mul_b);
  assign fixed     = diff_q[32] ? (diff_q + SchM) : diff_q;

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_val_q};

  // shared multiplier operands
  always_comb begin
    mul_a = LoW'(SchR);
    mul_b = WordW'(quo_q);
    unique case (state_q)
      ST_EST: begin
        mul_a = SchC;
        mul_b = rem_q;
      end
      ST_REM: begin
        mul_a = SchQ[LoW-1:0];
        mul_b = WordW'(quo_q);
      end
      ST_MUL_LO: begin
        mul_a = LoW'(SchA);
        mul_b = rem_q;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          state_d = (s_axis_tuser_i == FuncDraw && seeded_q) ? ST_RD : ST_SEED;
        end
      end
      ST_SEED:   state_d = ST_ABS;
      ST_ABS:    state_d = ST_EST;
      ST_EST:    state_d = ST_REM;
      ST_REM:    state_d = ST_CORR;
      ST_CORR:   state_d = ST_MUL_LO;
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_SUB;
      ST_SUB:    state_d = ST_FIX;
      ST_FIX:    state_d = last_word ? ST_RD : ST_ABS;
      ST_RD:     state_d = ST_WB;
      ST_WB: begin
        if (disc_q) begin
          state_d = !last_disc ? ST_RD : (pend_q ? ST_RD : ST_IDLE);
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready_o = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = front_q;
    mem_wdata       = sum;
    rd_en           = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_SEED: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = seed_q;
      end
      ST_FIX: begin
        mem_we    = 1'b1;
        mem_waddr = widx_q;
        mem_wdata = fixed[31:0];
      end
      ST_RD: rd_en = 1'b1;
      ST_WB: mem_we = disc_q || out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      front_q   <= IdxW'(Separation);
      rear_q    <= '0;
      seeded_q  <= 1'b0;
      disc_q    <= 1'b0;
      pend_q    <= 1'b0;
      dcnt_q    <= '0;
      widx_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_WB && !disc_q && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            disc_q <= 1'b0;
            pend_q <= (s_axis_tuser_i == FuncDraw);
          end
        end
        ST_SEED: widx_q <= IdxW'(1);
        ST_FIX: begin
          widx_q <= next_idx(widx_q);
          if (last_word) begin
            front_q  <= IdxW'(Separation);
            rear_q   <= '0;
            seeded_q <= 1'b1;
            disc_q   <= 1'b1;
            dcnt_q   <= '0;
          end
        end
        ST_WB: begin
          if (disc_q || out_free) begin
            front_q <= next_idx(front_q);
            rear_q  <= next_idx(rear_q);
          end
          if (disc_q) begin
            dcnt_q <= dcnt_q + DiscW'(1);
            if (last_disc) begin
              disc_q <= 1'b0;
              pend_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          if (s_axis_tuser_i == FuncSeed && s_axis_tdata_i != '0) begin
            seed_q <= s_axis_tdata_i;
          end else begin
            seed_q <= 32'd1;
          end
        end
      end
      ST_SEED: prev_q <= seed_q;
      ST_ABS: begin
        neg_q <= prev_q[31];
        rem_q <= mag;
      end
      ST_EST:  quo_q <= prod[SchShift +: QuoW];
      ST_REM:  rem_q <= rem_q - prod[WordW-1:0];
      ST_CORR: begin
        if (rem_q >= SchQ) begin
          rem_q <= rem_q - SchQ;
          quo_q <= quo_q + QuoW'(1);
        end
      end
      ST_MUL_LO: p_lo_q <= prod[WordW-1:0];
      ST_MUL_HI: p_hi_q <= prod[WordW-1:0];
      ST_SUB: begin
        if (neg_q) begin
          diff_q <= {1'b0, p_hi_q} - {1'b0, p_lo_q};
        end else begin
          diff_q <= {1'b0, p_lo_q} - {1'b0, p_hi_q};
        end
      end
      ST_FIX: prev_q <= fixed[31:0];
      ST_WB: begin
        if (!disc_q && out_free) begin
          out_val_q <= sum[WordW-1:1];
        end
      end
      default: ;
    endcase
  end

  // lag table: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rda_q <= mem_q[front_q];
      rdb_q <= mem_q[rear_q];
    end
  end

endmodule
`default_nettype wire

// ----- design/afp_checker.sv -----
// afp_checker: port-level assertions for additive_feedback_prng, bound to the top level.
// Depends on additive_feedback_prng ports only.
`default_nettype none
module afp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o
);

  a_no_result_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("result valid during reset");

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready did not drop after a request");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result appeared while idle");

  a_value_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[31])
    else $error("value wider than 31 bits");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule

bind additive_feedback_prng afp_checker u_afp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire
